/* design/hic_pkg.sv */
// ----------------------------------------------------------------------------
// hic_pkg: shared types and constants for the Celsius heat-index block
// Holds the item format, the fixed-point coefficients and the widths of the
// polynomial datapath.
// ----------------------------------------------------------------------------
package hic_pkg;

    localparam int T_W   = 11;
    localparam int H_W   = 10;
    localparam int OUT_W = 14;

    localparam int COEF_FRAC_BITS = 24;
    localparam int FRAC = (COEF_FRAC_BITS < 16) ? 16 :
                          (COEF_FRAC_BITS > 32) ? 32 : COEF_FRAC_BITS;

    // polynomial sum width: terms stay below 2^(FRAC+26), bias below 2^(FRAC+38)
    localparam int SW = FRAC + 40;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // arithmetic pipeline depth ahead of the output register
    localparam int NSTG = 7;

    localparam logic signed [T_W-1:0] T_MIN = 11'sd270;
    localparam logic [H_W-1:0]        H_MIN = 10'd400;
    localparam logic [H_W-1:0]        H_MAX = 10'd1000;
    localparam logic signed [19:0]    OUT_LOW  = -20'sd400;
    localparam logic signed [19:0]    OUT_HIGH = 20'sd8000;

    // coefficient magnitudes scaled by 2^32
    localparam longint unsigned C00 = 64'd37729977730;
    localparam longint unsigned C10 = 64'd6920885003;
    localparam longint unsigned C01 = 64'd10043991475;
    localparam longint unsigned C11 = 64'd627563656;
    localparam longint unsigned C20 = 64'd52862861;
    localparam longint unsigned C02 = 64'd70544099;
    localparam longint unsigned C21 = 64'd9499317;
    localparam longint unsigned C12 = 64'd3115827;
    localparam longint unsigned C22 = 64'd15385;

    function automatic longint unsigned coef(input longint unsigned k32);
        int unsigned sh;
        sh = 32 - FRAC;
        if (sh == 0) begin
            return k32;
        end
        return (k32 + (64'd1 << (sh - 1))) >> sh;
    endfunction

    // offset that keeps the scaled sum non-negative before the divide by 1000
    localparam int            DIV_OFFS_EXP = 17;
    localparam longint        DIV_OFFS     = 64'sd1000 << DIV_OFFS_EXP;
    localparam longint        DIV_D        = 64'sd1000 << FRAC;
    localparam longint        BIAS64 = DIV_D / 2 + (DIV_OFFS << FRAC)
                                       - longint'(coef(C00)) * 10000;

    localparam logic signed [SW-1:0] BIAS = SW'(BIAS64);
    localparam logic signed [SW-1:0] A10  = SW'(coef(C10) * 1000);
    localparam logic signed [SW-1:0] A01  = SW'(coef(C01) * 1000);
    localparam logic signed [SW-1:0] A11  = SW'(coef(C11) * 100);
    localparam logic signed [SW-1:0] A20  = SW'(coef(C20) * 100);
    localparam logic signed [SW-1:0] A02  = SW'(coef(C02) * 100);
    localparam logic signed [SW-1:0] A21  = SW'(coef(C21) * 10);
    localparam logic signed [SW-1:0] A12  = SW'(coef(C12) * 10);
    localparam logic signed [SW-1:0] A22  = SW'(coef(C22));

    // floor(u / 1000) = (u * RECIP) >> RECIP_SH for u < 2^U_W
    localparam int              U_W      = 28;
    localparam int              RECIP_W  = 29;
    localparam int              RECIP_SH = 38;
    localparam logic [RECIP_W-1:0] RECIP = 29'd274877907;
    localparam int              PROD_W   = U_W + RECIP_W;
    localparam int              QUO_W    = PROD_W - RECIP_SH;

    typedef struct packed {
        logic signed [T_W-1:0] temp;
        logic [H_W-1:0]        hum;
        logic                  used;
    } hic_item_t;

endpackage

/* design/hic_front.sv */
// ----------------------------------------------------------------------------
// hic_front: input stage
// Accepts readings, clamps humidity and decides between the polynomial and
// pass-through.
// ----------------------------------------------------------------------------
module hic_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [10:0]       s_temperature,
    input  logic [9:0]               s_humidity,
    output logic                     out_valid,
    input  logic                     out_ready,
    output hic_pkg::hic_item_t       out_item
);
    import hic_pkg::*;

    logic      valid_reg;
    hic_item_t item_reg;
    hic_item_t item_next;

    assign s_ready   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        item_next.temp = s_temperature;
        item_next.hum  = (s_humidity > H_MAX) ? H_MAX : s_humidity;
        item_next.used = (s_temperature >= T_MIN) && (item_next.hum >= H_MIN);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

/* design/hic_queue.sv */
// ----------------------------------------------------------------------------
// hic_queue: small FIFO between front and back
// Lets the input stage and the arithmetic pipeline stall independently.
// ----------------------------------------------------------------------------
module hic_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  hic_pkg::hic_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output hic_pkg::hic_item_t  out_item
);
    import hic_pkg::*;

    hic_item_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               wr_en;
    logic               rd_en;

    assign in_ready  = (count_reg != QCNT_W'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign wr_en     = in_valid && in_ready;
    assign rd_en     = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en) begin
                count_reg <= count_reg + 1'b1;
            end else if (rd_en && !wr_en) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* design/hic_back.sv */
// ----------------------------------------------------------------------------
// hic_back: polynomial pipeline
// Monomials, coefficient products, adder tree, divide by 1000 through a
// reciprocal multiply, then clamp into the output register.
// ----------------------------------------------------------------------------
module hic_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  hic_pkg::hic_item_t        in_item,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [13:0]        m_apparent_temperature,
    output logic                      m_formula_used,
    output logic                      m_saturated
);
    import hic_pkg::*;

    logic                    adv;
    logic [NSTG-1:0]         vld_reg;
    logic                    m_valid_reg;
    logic signed [T_W-1:0]   t_reg    [NSTG];
    logic                    used_reg [NSTG];

    logic signed [T_W-1:0]   h0;
    logic signed [T_W-1:0]   h1_reg, h2_reg;
    logic signed [21:0]      tt1_reg, th1_reg, tt2_reg, th2_reg;
    logic signed [20:0]      hh1_reg, hh2_reg;
    logic signed [30:0]      tth2_reg, thh2_reg;
    logic signed [40:0]      tthh2_reg;

    logic signed [SW-1:0]    p10_reg, p01_reg, p11_reg, p20_reg;
    logic signed [SW-1:0]    p02_reg, p21_reg, p12_reg, p22_reg;
    logic signed [SW-1:0]    a_reg, b_reg, c_reg, d_reg;
    logic signed [SW-1:0]    ab_reg, cd_reg;
    logic signed [SW-1:0]    sum;
    logic [U_W-1:0]          u_reg;
    logic [PROD_W-1:0]       prod_reg;

    logic signed [19:0]      quo;
    logic signed [19:0]      r_sel;
    logic signed [OUT_W-1:0] r_next;
    logic                    sat_next;
    logic signed [OUT_W-1:0] r_reg;
    logic                    used_out_reg;
    logic                    sat_reg;

    assign adv      = !m_valid_reg || m_ready;
    assign in_ready = adv;
    assign h0       = $signed({1'b0, in_item.hum});
    assign sum      = ab_reg + cd_reg;

    assign m_valid                = m_valid_reg;
    assign m_apparent_temperature = r_reg;
    assign m_formula_used         = used_out_reg;
    assign m_saturated            = sat_reg;

    always_comb begin
        quo = $signed({{(20 - QUO_W){1'b0}}, prod_reg[PROD_W-1:RECIP_SH]})
              - (20'sd1 <<< DIV_OFFS_EXP);
        r_sel = used_reg[NSTG-1] ? quo
                                 : 20'(t_reg[NSTG-1]);
        sat_next = 1'b0;
        r_next   = OUT_W'(r_sel);
        if (r_sel < OUT_LOW) begin
            r_next   = OUT_W'(OUT_LOW);
            sat_next = 1'b1;
        end else if (r_sel > OUT_HIGH) begin
            r_next   = OUT_W'(OUT_HIGH);
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[NSTG-2:0], in_valid};
            m_valid_reg <= vld_reg[NSTG-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t_reg[0]    <= in_item.temp;
            used_reg[0] <= in_item.used;
            for (int i = 1; i < NSTG; i++) begin
                t_reg[i]    <= t_reg[i-1];
                used_reg[i] <= used_reg[i-1];
            end

            h1_reg  <= h0;
            tt1_reg <= in_item.temp * in_item.temp;
            th1_reg <= in_item.temp * h0;
            hh1_reg <= h0 * h0;

            h2_reg    <= h1_reg;
            tt2_reg   <= tt1_reg;
            th2_reg   <= th1_reg;
            hh2_reg   <= hh1_reg;
            tth2_reg  <= tt1_reg * h1_reg;
            thh2_reg  <= th1_reg * h1_reg;
            tthh2_reg <= tt1_reg * hh1_reg;

            p10_reg <= A10 * t_reg[1];
            p01_reg <= A01 * h2_reg;
            p11_reg <= A11 * th2_reg;
            p20_reg <= A20 * tt2_reg;
            p02_reg <= A02 * hh2_reg;
            p21_reg <= A21 * tth2_reg;
            p12_reg <= A12 * thh2_reg;
            p22_reg <= A22 * tthh2_reg;

            a_reg <= p10_reg + p01_reg + BIAS;
            b_reg <= -p11_reg - p20_reg;
            c_reg <= p21_reg - p02_reg;
            d_reg <= p12_reg - p22_reg;

            ab_reg <= a_reg + b_reg;
            cd_reg <= c_reg + d_reg;

            u_reg <= sum[FRAC +: U_W];

            prod_reg <= u_reg * RECIP;

            r_reg        <= r_next;
            used_out_reg <= used_reg[NSTG-1];
            sat_reg      <= sat_next;
        end
    end

endmodule

/* design/heat_index_celsius.sv */
// ----------------------------------------------------------------------------
// heat_index_celsius: Celsius heat index in fixed point
// Applies the nine-term heat-index polynomial when temperature >= 27.0 C
// and humidity >= 40.0 %, else passes the temperature through; saturates.
//
//   channel   dir   handshake           payload
//   s_        in    s_valid / s_ready   temperature (s11), humidity (u10)
//   m_        out   m_valid / m_ready   apparent_temperature (s14),
//                                       formula_used, saturated
//
// One transaction per cycle sustained while m_ready is high. With an empty
// queue, an accepted input passes one input register, one queue slot and
// seven arithmetic stages plus the output register before m_valid rises.
// A 4-entry queue separates the input stage from the pipeline; the pipeline
// freezes only while the output register holds an untaken result.
// Reset is synchronous and active low and empties every stage.
// ----------------------------------------------------------------------------
module heat_index_celsius (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [10:0] s_temperature,
    input  logic [9:0]         s_humidity,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [13:0] m_apparent_temperature,
    output logic               m_formula_used,
    output logic               m_saturated
);
    import hic_pkg::*;

    logic      fq_valid;
    logic      fq_ready;
    hic_item_t fq_item;
    logic      qb_valid;
    logic      qb_ready;
    hic_item_t qb_item;

    hic_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_temperature (s_temperature),
        .s_humidity    (s_humidity),
        .out_valid     (fq_valid),
        .out_ready     (fq_ready),
        .out_item      (fq_item)
    );

    hic_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    hic_back u_back (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .in_valid               (qb_valid),
        .in_ready               (qb_ready),
        .in_item                (qb_item),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_apparent_temperature (m_apparent_temperature),
        .m_formula_used         (m_formula_used),
        .m_saturated            (m_saturated)
    );

    a_sat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |->
        (m_apparent_temperature == -14'sd400 || m_apparent_temperature == 14'sd8000))
        else $error("saturated result not at a range bound");

    a_pass_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_formula_used && !m_saturated) |->
        (m_apparent_temperature >= -14'sd400 && m_apparent_temperature <= 14'sd1023))
        else $error("pass-through result outside temperature range");

    a_pass_nosat_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_formula_used && m_saturated) |->
        (m_apparent_temperature == -14'sd400))
        else $error("pass-through clamped at upper bound");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for heat_index_celsius
// Drives temperature/humidity readings through the valid/ready input channel,
// predicts each heat-index result in integer arithmetic and compares it with
// every transaction taken from the output channel. Covers pass-through,
// thresholds, humidity clamping, saturation, random bursts and backpressure.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int  CLK_HALF        = 6;
    localparam int  RESET_CYCLES    = 9;
    localparam int  HOLD_OFF_CYCLES = 250;
    localparam int  WATCHDOG_LIMIT  = 2000;
    localparam int  DRAIN_CYCLES    = 30;
    localparam int  MAX_REPORTS     = 40;

    localparam longint TEMP_THRESH = 270;
    localparam longint HUM_THRESH  = 400;
    localparam longint HUM_CLAMP   = 1000;
    localparam longint APP_MIN     = -400;
    localparam longint APP_MAX     = 8000;

    // coefficient magnitudes, scaled by 2^32
    localparam longint unsigned K_CONST = 64'd37729977730;
    localparam longint unsigned K_T     = 64'd6920885003;
    localparam longint unsigned K_H     = 64'd10043991475;
    localparam longint unsigned K_TH    = 64'd627563656;
    localparam longint unsigned K_TT    = 64'd52862861;
    localparam longint unsigned K_HH    = 64'd70544099;
    localparam longint unsigned K_TTH   = 64'd9499317;
    localparam longint unsigned K_THH   = 64'd3115827;
    localparam longint unsigned K_TTHH  = 64'd15385;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;

    typedef struct packed {
        logic signed [13:0] apparent;
        logic               used;
        logic               sat;
    } heat_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [10:0] s_temperature = '0;
    logic [9:0]         s_humidity = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [13:0] m_apparent_temperature;
    logic               m_formula_used;
    logic               m_saturated;

    heat_result_t expected_results[$];
    int           err_count = 0;
    rx_mode_t     rx_mode = RX_ALWAYS;
    bit           hold_off_req = 1'b0;

    heat_index_celsius dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_temperature          (s_temperature),
        .s_humidity             (s_humidity),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_apparent_temperature (m_apparent_temperature),
        .m_formula_used         (m_formula_used),
        .m_saturated            (m_saturated)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic longint scaled_coef(input longint unsigned k32);
        int unsigned shift;
        shift = 32 - hic_pkg::FRAC;
        if (shift == 0) begin
            return longint'(k32);
        end
        return longint'((k32 + (64'd1 << (shift - 1))) >> shift);
    endfunction

    function automatic heat_result_t predict_heat_index(input logic signed [10:0] temp_in,
                                                        input logic [9:0] hum_in);
        longint       t;
        longint       h;
        longint       sum;
        longint       div;
        longint       biased;
        longint       r;
        heat_result_t res;
        t = temp_in;
        h = hum_in;
        if (h > HUM_CLAMP) begin
            h = HUM_CLAMP;
        end
        res.used = 1'b0;
        res.sat  = 1'b0;
        if (t < TEMP_THRESH || h < HUM_THRESH) begin
            r = t;
        end else begin
            res.used = 1'b1;
            div = longint'(1000) << hic_pkg::FRAC;
            sum = -scaled_coef(K_CONST) * 10000
                  + scaled_coef(K_T) * t * 1000
                  + scaled_coef(K_H) * h * 1000
                  - scaled_coef(K_TH) * t * h * 100
                  - scaled_coef(K_TT) * t * t * 100
                  - scaled_coef(K_HH) * h * h * 100
                  + scaled_coef(K_TTH) * t * t * h * 10
                  + scaled_coef(K_THH) * t * h * h * 10
                  - scaled_coef(K_TTHH) * t * t * h * h;
            biased = sum + div / 2;
            if (biased >= 0) begin
                r = biased / div;
            end else begin
                r = -((-biased + div - 1) / div);
            end
        end
        if (r < APP_MIN) begin
            r = APP_MIN;
            res.sat = 1'b1;
        end
        if (r > APP_MAX) begin
            r = APP_MAX;
            res.sat = 1'b1;
        end
        res.apparent = r[13:0];
        return res;
    endfunction

    // payload stays put until the transaction is taken
    task automatic send_reading(input logic signed [10:0] t, input logic [9:0] h);
        s_valid       <= 1'b1;
        s_temperature <= t;
        s_humidity    <= h;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(predict_heat_index(t, h));
    endtask

    task automatic pause_sender(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic report_mismatch(input string field, input longint want, input longint got);
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
        err_count++;
    endtask

    always @(posedge aclk) begin
        heat_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                if (err_count < MAX_REPORTS) begin
                    $error("result transaction with no expected result pending");
                end
                err_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_apparent_temperature !== want.apparent) begin
                    report_mismatch("apparent_temperature", want.apparent,
                                    m_apparent_temperature);
                end
                if (m_formula_used !== want.used) begin
                    report_mismatch("formula_used", want.used, m_formula_used);
                end
                if (m_saturated !== want.sat) begin
                    report_mismatch("saturated", want.sat, m_saturated);
                end
            end
        end
    end

    initial begin
        int unsigned rx_tick;
        rx_tick = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            rx_tick++;
            case (rx_mode)
                RX_ALWAYS:  m_ready <= 1'b1;
                RX_RANDOM:  m_ready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: m_ready <= ((rx_tick % 11) < 7);
                default:    m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("FAIL heat_index_celsius");
        $finish;
    end

    task automatic test_pass_through();
        send_reading(-11'sd1024, 10'd500);
        send_reading(-11'sd401, 10'd700);
        send_reading(-11'sd400, 10'd1000);
        send_reading(-11'sd1, 10'd0);
        send_reading(11'sd0, 10'd1023);
        send_reading(11'sd269, 10'd1000);
        send_reading(11'sd800, 10'd0);
        send_reading(11'sd1023, 10'd399);
        pause_sender(1);
    endtask

    task automatic test_thresholds();
        send_reading(11'sd270, 10'd400);
        send_reading(11'sd269, 10'd400);
        send_reading(11'sd270, 10'd399);
        send_reading(11'sd271, 10'd401);
        send_reading(11'sd800, 10'd400);
        send_reading(11'sd270, 10'd1000);
        pause_sender(1);
    endtask

    task automatic test_humidity_clamp();
        send_reading(11'sd350, 10'd1000);
        send_reading(11'sd350, 10'd1001);
        send_reading(11'sd350, 10'd1023);
        send_reading(11'sd800, 10'd1023);
        pause_sender(1);
    endtask

    task automatic test_saturation();
        send_reading(11'sd1023, 10'd1023);
        send_reading(11'sd900, 10'd800);
        send_reading(-11'sd512, 10'd600);
        pause_sender(1);
    endtask

    task automatic test_random_readings(input int count, input int max_gap, input rx_mode_t mode);
        int                 sent;
        int                 burst;
        int                 gap;
        int unsigned        sel;
        logic signed [10:0] t;
        logic [9:0]         h;
        rx_mode = mode;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 32);
            for (int i = 0; i < burst && sent < count; i++) begin
                sel = $urandom_range(0, 99);
                if (sel < 65) begin
                    t = 11'($urandom_range(270, 1023));
                    h = 10'($urandom_range(400, 1023));
                end else if (sel < 75) begin
                    t = 11'($urandom_range(266, 274));
                    h = 10'($urandom_range(396, 404));
                end else begin
                    t = 11'($urandom_range(0, 2047));
                    h = 10'($urandom_range(0, 1023));
                end
                send_reading(t, h);
                sent++;
            end
            gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
            if (gap > 0) begin
                pause_sender(gap);
            end
        end
        pause_sender(1);
    endtask

    task automatic test_backpressure();
        rx_mode = RX_ALWAYS;
        hold_off_req = 1'b1;
        for (int i = 0; i < 40; i++) begin
            send_reading(11'($urandom_range(270, 1023)), 10'($urandom_range(400, 1023)));
        end
        pause_sender(1);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_pass_through();
        test_thresholds();
        test_humidity_clamp();
        test_saturation();
        test_random_readings(400, 0, RX_ALWAYS);
        test_backpressure();
        test_random_readings(400, 4, RX_RANDOM);
        test_random_readings(350, 8, RX_PATTERN);
        test_random_readings(350, 3, RX_SPARSE);

        rx_mode = RX_RANDOM;
        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_count == 0 && expected_results.size() == 0) begin
            $display("PASS heat_index_celsius");
        end else begin
            $display("FAIL heat_index_celsius");
        end
        $finish;
    end

endmodule
